// ===== hdl/twsd_pkg.sv =====
// ----------------------------------------------------------------------------
// twsd_pkg
// Shared types, constants and helpers for the three-way switch debouncer.
// ----------------------------------------------------------------------------
package twsd_pkg;

	localparam int SWITCHES = 8;
	localparam int CNT_W    = $clog2(SWITCHES + 1);
	localparam int TIME_W   = 32;
	localparam int DEB_W    = 16;
	localparam int TGT_W    = 16;
	localparam int PIN_W    = 8;
	localparam int PCT_W    = 7;
	localparam int PCT_SCALE = 100;

	// item kinds
	localparam logic [1:0] OP_TICK     = 2'd0;
	localparam logic [1:0] OP_ACTIVATE = 2'd1;
	localparam logic [1:0] OP_FORCE    = 2'd2;

	// switch position codes
	localparam logic [1:0] POS_LEFT    = 2'd0;
	localparam logic [1:0] POS_CENTRE  = 2'd1;
	localparam logic [1:0] POS_RIGHT   = 2'd2;
	localparam logic [1:0] POS_INVALID = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_TARGET   = 2'd1;

	typedef struct packed {
		logic changed;
		logic match;
	} lane_stat_t;

	typedef struct packed {
		logic             armed;
		logic [PCT_W-1:0] percent;
		logic [3:0]       match_count;
		logic             solved;
	} result_t;

	function automatic logic [1:0] decode_pins(input logic l, input logic r);
		logic [1:0] p;
		case ({l, r})
			2'b10:   p = POS_LEFT;
			2'b01:   p = POS_RIGHT;
			2'b00:   p = POS_CENTRE;
			default: p = POS_INVALID;
		endcase
		return p;
	endfunction

	function automatic logic [PCT_W-1:0] percent_of(input logic [CNT_W-1:0] cnt);
		logic [CNT_W+6:0] prod;
		logic [CNT_W+6:0] quo;
		prod = (CNT_W + 7)'(cnt) * (CNT_W + 7)'(PCT_SCALE);
		quo  = prod / (CNT_W + 7)'(SWITCHES);
		return quo[PCT_W-1:0];
	endfunction

endpackage

// ===== hdl/twsd_lane.sv =====
// ----------------------------------------------------------------------------
// twsd_lane
// Debounce core for one switch: raw and stable position plus change time.
// ----------------------------------------------------------------------------
module twsd_lane (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [1:0]                  op,
	input  logic                        active,
	input  logic [twsd_pkg::TIME_W-1:0] now_ms,
	input  logic                        left_low,
	input  logic                        right_low,
	input  logic [twsd_pkg::DEB_W-1:0]  debounce_time,
	input  logic [1:0]                  target,
	output twsd_pkg::lane_stat_t        stat
);
	import twsd_pkg::*;

	logic [1:0]        raw_q;
	logic [1:0]        stable_q;
	logic [TIME_W-1:0] time_q;

	logic [1:0]        pos;
	logic              raw_chg;
	logic [TIME_W-1:0] time_n;
	logic [TIME_W-1:0] elapsed;
	logic              settled;
	logic [1:0]        raw_n;
	logic [1:0]        stable_n;
	logic              changed;

	always_comb begin
		pos      = decode_pins(left_low, right_low);
		raw_chg  = pos != raw_q;
		raw_n    = raw_q;
		time_n   = time_q;
		stable_n = stable_q;
		changed  = 1'b0;
		elapsed  = now_ms - (raw_chg ? now_ms : time_q);
		settled  = elapsed >= TIME_W'(debounce_time);
		case (op)
			OP_ACTIVATE: begin
				raw_n    = pos;
				stable_n = pos;
				time_n   = now_ms;
			end
			OP_FORCE: begin
				stable_n = target;
			end
			OP_TICK: begin
				if (active) begin
					if (raw_chg) begin
						raw_n  = pos;
						time_n = now_ms;
					end
					if (settled && pos != stable_q) begin
						stable_n = pos;
						changed  = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.changed = changed;
	assign stat.match   = (stable_n != POS_INVALID) && (stable_n == target);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q    <= POS_INVALID;
			stable_q <= POS_INVALID;
			time_q   <= '0;
		end else if (en) begin
			raw_q    <= raw_n;
			stable_q <= stable_n;
			time_q   <= time_n;
		end
	end

endmodule

// ===== hdl/twsd_merge.sv =====
// ----------------------------------------------------------------------------
// twsd_merge
// Combines lane status into the match total, armed flag and result fields.
// ----------------------------------------------------------------------------
module twsd_merge (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     en,
	input  logic [1:0]                               op,
	input  twsd_pkg::lane_stat_t [twsd_pkg::SWITCHES-1:0] stat,
	output logic                                     active,
	output twsd_pkg::result_t                        result
);
	import twsd_pkg::*;

	logic             active_q;
	logic [CNT_W-1:0] total_q;
	logic             active_n;
	logic [CNT_W-1:0] total_n;
	logic [CNT_W-1:0] count;
	logic             any_chg;

	always_comb begin
		count   = '0;
		any_chg = 1'b0;
		for (int i = 0; i < SWITCHES; i++) begin
			count   = count + CNT_W'(stat[i].match);
			any_chg = any_chg | stat[i].changed;
		end
	end

	always_comb begin
		active_n = active_q;
		total_n  = total_q;
		case (op)
			OP_ACTIVATE: begin
				active_n = 1'b1;
				total_n  = count;
			end
			OP_FORCE: begin
				active_n = 1'b1;
				total_n  = CNT_W'(SWITCHES);
			end
			OP_TICK: begin
				// any_chg is only raised while active
				if (any_chg) begin
					total_n = count;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		result.armed       = active_n;
		result.solved      = active_n && (total_n >= CNT_W'(SWITCHES));
		result.match_count = 4'(total_n);
		result.percent     = percent_of(total_n);
	end

	assign active = active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			total_q  <= '0;
		end else if (en) begin
			active_q <= active_n;
			total_q  <= total_n;
		end
	end

endmodule

// ===== hdl/three_way_switch_debounce_match.sv =====
// ----------------------------------------------------------------------------
// three_way_switch_debounce_match
// Debounces eight three-position switches and matches them to a target.
// ----------------------------------------------------------------------------
// Usage: each input item on s_* carries the kind of operation in s_tuser
// (tick, activate, force solve) and a timestamp plus active-low pin samples
// in s_tdata. Every accepted item yields exactly one result item on m_*:
// solved flag, match count, progress percent and armed flag.
// The eight switches are handled by eight lanes side by side; a merge stage
// counts matches and updates the total in the same cycle, so one item is
// taken every clock while s_tready is high. Each result is registered in the
// output register that drives m_*, or in the skid register while it is full.
// The result side has an output register plus a skid register: while a
// result waits, one more item is still accepted; s_tready drops only when
// both hold results, and rises again as soon as the receiver takes one.
// The cfg_* channel writes debounce_time (index 0) or target_combination
// (index 1) and is always ready; other indexes are ignored.
// Reset: debounce time 50 ms, target 0, all positions invalid, change times
// zero, block inactive and no results pending.
// ----------------------------------------------------------------------------
module three_way_switch_debounce_match (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // now_ms[31:0], left_low[39:32], right_low[47:40]
	input  logic [1:0]  s_tuser,  // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // solved[0], match_count[4:1], progress_percent[11:5],
	                              // armed[12], zero fill [15:13]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import twsd_pkg::*;

	logic [DEB_W-1:0]  debounce_q;
	logic [TGT_W-1:0]  target_q;

	logic              s_fire;
	logic              m_fire;
	logic [TIME_W-1:0] now_ms;
	logic [PIN_W-1:0]  left_low;
	logic [PIN_W-1:0]  right_low;
	logic              active;
	result_t           result;
	lane_stat_t [SWITCHES-1:0] stat;

	result_t           out_q;
	logic              out_valid_q;
	result_t           skid_q;
	logic              skid_valid_q;

	assign now_ms    = s_tdata[31:0];
	assign left_low  = s_tdata[39:32];
	assign right_low = s_tdata[47:40];

	assign s_tready  = !skid_valid_q;
	assign s_fire    = s_tvalid && s_tready;
	assign m_fire    = out_valid_q && m_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEB_W'(50);
			target_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_data;
				REG_TARGET:   target_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	for (genvar g = 0; g < SWITCHES; g++) begin : g_lane
		twsd_lane u_lane (
			.clk           (clk),
			.arst_n        (arst_n),
			.en            (s_fire),
			.op            (s_tuser),
			.active        (active),
			.now_ms        (now_ms),
			.left_low      (left_low[g]),
			.right_low     (right_low[g]),
			.debounce_time (debounce_q),
			.target        (target_q[2*g +: 2]),
			.stat          (stat[g])
		);
	end

	twsd_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (s_fire),
		.op     (s_tuser),
		.stat   (stat),
		.active (active),
		.result (result)
	);

	// output register with skid stage behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_fire) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= s_fire;
			end
		end else if (s_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_fire) begin
			out_q <= skid_valid_q ? skid_q : result;
		end else if (s_fire) begin
			skid_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q};

endmodule

// ===== tb/sv/three_way_switch_debounce_match_tb.sv =====
// ----------------------------------------------------------------------------
// three_way_switch_debounce_match_tb
// Self-checking bench for the eight-switch debouncer with target matching.
// A scripted opening walks reset behavior, every op, invalid positions,
// unmatched target codes, stale counts after a target write, timestamp wrap
// and the debounce extremes. Random phases follow, each with fresh register
// settings and mostly settled switch patterns with bounce and noise mixed in.
// Both stream sides idle at random. Every result is checked against a
// behavioral model of the block or against a scripted expectation.
// ----------------------------------------------------------------------------
module three_way_switch_debounce_match_tb;

	import twsd_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam logic [1:0] REG_SPARE_A = 2'd2;
	localparam logic [1:0] REG_SPARE_B = 2'd3;
	localparam int         IDLE_LIMIT  = 4000;
	localparam int         PHASES      = 12;
	localparam int         PHASE_ITEMS = 85;

	localparam result_t RES_IDLE   = '0;
	localparam result_t RES_ARMED  = '{armed: 1'b1, percent: 7'd0, match_count: 4'd0,
		solved: 1'b0};
	localparam result_t RES_SOLVED = '{armed: 1'b1, percent: 7'd100, match_count: 4'd8,
		solved: 1'b1};

	typedef enum {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [1:0]  code;   // op for items, register index for writes
		logic [31:0] now;
		logic [7:0]  left_pins;
		logic [7:0]  right_pins;
		logic [15:0] value;
		bit          typed;
		result_t     exp;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0]  s_tuser = OP_TICK;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_DEBOUNCE;
	logic [15:0] cfg_data = '0;

	// typed expectation travels with the item it belongs to
	bit          item_typed = 1'b0;
	result_t     item_exp = '0;

	// model state
	logic [15:0] settle_window = 16'd50;
	logic [15:0] target_codes = '0;
	logic [1:0]  raw_pos [SWITCHES];
	logic [1:0]  stable_pos [SWITCHES];
	logic [31:0] changed_at [SWITCHES];
	bit          armed_now = 1'b0;
	int unsigned matched = 0;

	result_t     pending_status [$];
	row_t        script [$];
	bit          steady = 1'b0;
	int          errors = 0;
	int          idle_cycles = 0;
	int          op_seen [4] = '{0, 0, 0, 0};
	int          writes_seen = 0;
	int          results_seen = 0;
	int          solved_seen = 0;

	three_way_switch_debounce_match DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		for (int k = 0; k < SWITCHES; k++) begin
			raw_pos[k] = POS_INVALID;
			stable_pos[k] = POS_INVALID;
			changed_at[k] = '0;
		end
	end

	function automatic logic [1:0] pin_position(input logic l, input logic r);
		if (l && r)
			return POS_INVALID;
		if (l)
			return POS_LEFT;
		if (r)
			return POS_RIGHT;
		return POS_CENTRE;
	endfunction

	function automatic int unsigned count_on_target();
		int unsigned hits;
		hits = 0;
		for (int k = 0; k < SWITCHES; k++)
			if (stable_pos[k] != POS_INVALID && stable_pos[k] == target_codes[2*k +: 2])
				hits++;
		return hits;
	endfunction

	function automatic result_t debounce_and_match(input logic [1:0] op,
			input logic [31:0] now, input logic [7:0] l, input logic [7:0] r);
		logic [1:0]  p;
		logic [31:0] age;
		bit          moved;
		result_t     res;
		moved = 1'b0;
		if (op == OP_ACTIVATE) begin
			armed_now = 1'b1;
			for (int k = 0; k < SWITCHES; k++) begin
				p = pin_position(l[k], r[k]);
				raw_pos[k] = p;
				stable_pos[k] = p;
				changed_at[k] = now;
			end
			matched = count_on_target();
		end else if (op == OP_FORCE) begin
			armed_now = 1'b1;
			matched = SWITCHES;
			for (int k = 0; k < SWITCHES; k++)
				stable_pos[k] = target_codes[2*k +: 2];
		end else if (op == OP_TICK && armed_now) begin
			for (int k = 0; k < SWITCHES; k++) begin
				p = pin_position(l[k], r[k]);
				if (p != raw_pos[k]) begin
					raw_pos[k] = p;
					changed_at[k] = now;
				end
				age = now - changed_at[k];
				if (age >= {16'd0, settle_window} && p != stable_pos[k]) begin
					stable_pos[k] = p;
					moved = 1'b1;
				end
			end
			// recount against the current target only when a stable position moved
			if (moved)
				matched = count_on_target();
		end
		res.solved = armed_now && matched >= SWITCHES;
		res.match_count = 4'(matched);
		res.percent = 7'((matched * PCT_SCALE) / SWITCHES);
		res.armed = armed_now;
		return res;
	endfunction

	function automatic logic [15:0] pins_of(input logic [15:0] pos);
		logic [7:0] l;
		logic [7:0] r;
		for (int k = 0; k < SWITCHES; k++) begin
			l[k] = pos[2*k +: 2] == POS_LEFT || pos[2*k +: 2] == POS_INVALID;
			r[k] = pos[2*k +: 2] == POS_RIGHT || pos[2*k +: 2] == POS_INVALID;
		end
		return {r, l};
	endfunction

	function automatic int unsigned gap_len();
		int unsigned pick;
		if (steady)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void add_item(input logic [1:0] op, input logic [31:0] now,
			input logic [7:0] l, input logic [7:0] r);
		script.push_back('{ROW_ITEM, op, now, l, r, 16'd0, 1'b0, RES_IDLE});
	endfunction

	function automatic void add_checked(input logic [1:0] op, input logic [31:0] now,
			input logic [7:0] l, input logic [7:0] r, input result_t exp);
		script.push_back('{ROW_ITEM, op, now, l, r, 16'd0, 1'b1, exp});
	endfunction

	function automatic void add_write(input logic [1:0] idx, input logic [15:0] value);
		script.push_back('{ROW_REG, idx, 32'd0, 8'd0, 8'd0, value, 1'b0, RES_IDLE});
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	task automatic send_item(input logic [1:0] op, input logic [31:0] now,
			input logic [7:0] l, input logic [7:0] r, input bit typed, input result_t exp);
		int unsigned gap;
		gap = gap_len();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {r, l, now};
		s_tuser <= op;
		item_typed <= typed;
		item_exp <= exp;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// stop sending and hold off until every pending result has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_status.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// handshakes: prediction, checking, register tracking and the watchdog
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				writes_seen++;
				case (cfg_index)
					REG_DEBOUNCE: settle_window = cfg_data;
					REG_TARGET:   target_codes = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				want = debounce_and_match(s_tuser, s_tdata[31:0], s_tdata[39:32],
					s_tdata[47:40]);
				if (item_typed)
					want = item_exp;
				pending_status.push_back(want);
				op_seen[s_tuser]++;
			end
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[12:0]);
				results_seen++;
				if (got.solved)
					solved_seen++;
				if (pending_status.size() == 0) begin
					report_mismatch("result with nothing pending", 1, 0);
				end else begin
					want = pending_status.pop_front();
					if (got.solved != want.solved)
						report_mismatch("solved", got.solved, want.solved);
					if (got.match_count != want.match_count)
						report_mismatch("match_count", got.match_count, want.match_count);
					if (got.percent != want.percent)
						report_mismatch("progress_percent", got.percent, want.percent);
					if (got.armed != want.armed)
						report_mismatch("armed", got.armed, want.armed);
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
				$display("three_way_switch_debounce_match test failed");
				$finish;
			end
		end
	end

	// result side stalls
	initial begin
		int unsigned hold_off;
		wait (arst_n);
		forever begin
			hold_off = gap_len();
			if (hold_off != 0) begin
				m_tready <= 1'b0;
				repeat (hold_off) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin
		row_t        row;
		int unsigned deb;
		int unsigned pick;
		logic [15:0] tgt;
		logic [15:0] hold;
		logic [15:0] pins;
		logic [15:0] bounce;
		logic [31:0] now;
		logic [1:0]  op;
		int          k;

		// tick and unused op while inactive, force with the reset target
		add_checked(OP_TICK, 32'd0, 8'h00, 8'h00, RES_IDLE);
		add_checked(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF, 8'hFF, RES_IDLE);
		add_checked(OP_FORCE, 32'd5, 8'h00, 8'h00, RES_SOLVED);
		// centre pins settle just at the reset debounce time
		add_item(OP_TICK, 32'd10, 8'h00, 8'h00);
		add_item(OP_TICK, 32'd59, 8'h00, 8'h00);
		add_item(OP_TICK, 32'd60, 8'h00, 8'h00);
		// invalid positions never match, not even target code 3
		add_write(REG_TARGET, 16'hFFFF);
		add_checked(OP_ACTIVATE, 32'd100, 8'hFF, 8'hFF, RES_ARMED);
		add_checked(OP_UNUSED, 32'd200, 8'h00, 8'h00, RES_ARMED);
		add_write(REG_DEBOUNCE, 16'd0);
		add_write(REG_TARGET, 16'h9A65);
		add_write(REG_SPARE_A, 16'h0000);
		add_write(REG_SPARE_B, 16'hFFFF);
		add_item(OP_ACTIVATE, 32'd300, 8'hF0, 8'h0F);
		add_item(OP_TICK, 32'd300, 8'h0F, 8'hF0);
		add_item(OP_TICK, 32'd301, 8'h00, 8'h00);
		// new target leaves the count stale until a stable position moves
		add_write(REG_TARGET, 16'h5555);
		add_item(OP_UNUSED, 32'd302, 8'h00, 8'h00);
		add_item(OP_TICK, 32'd302, 8'h00, 8'h00);
		add_item(OP_TICK, 32'd303, 8'h01, 8'h00);
		// timestamp wraps across the debounce window
		add_write(REG_DEBOUNCE, 16'd20);
		add_item(OP_ACTIVATE, 32'hFFFF_FFF0, 8'h00, 8'h00);
		add_item(OP_TICK, 32'hFFFF_FFF8, 8'hFF, 8'h00);
		add_item(OP_TICK, 32'h0000_0007, 8'hFF, 8'h00);
		add_item(OP_TICK, 32'h0000_000C, 8'hFF, 8'h00);
		add_write(REG_DEBOUNCE, 16'hFFFF);
		add_item(OP_TICK, 32'h0000_0100, 8'h00, 8'hFF);
		add_item(OP_TICK, 32'h0001_00FE, 8'h00, 8'hFF);
		add_item(OP_TICK, 32'h0001_00FF, 8'h00, 8'hFF);
		// force solve with all-invalid targets still reports solved
		add_write(REG_TARGET, 16'hFFFF);
		add_checked(OP_FORCE, 32'h0002_0000, 8'h00, 8'h00, RES_SOLVED);
		add_item(OP_TICK, 32'h0002_0001, 8'h00, 8'h00);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			row = script[i];
			if (row.kind == ROW_REG) begin
				wait_drained();
				write_reg(row.code, row.value);
			end else begin
				send_item(row.code, row.now, row.left_pins, row.right_pins, row.typed,
					row.exp);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_drained();
			steady = phase % 4 == 3;
			case (phase)
				0: deb = 0;
				1: deb = 16'hFFFF;
				2: deb = 1;
				default: deb = $urandom_range(0, 1) ? $urandom_range(1, 40)
					: $urandom_range(0, 16'hFFFF);
			endcase
			if (phase == 0)
				tgt = 16'h0000;
			else if (phase == 1)
				tgt = 16'hFFFF;
			else if ($urandom_range(0, 2) == 0)
				tgt = 16'($urandom);
			else
				for (k = 0; k < SWITCHES; k++)
					tgt[2*k +: 2] = 2'($urandom_range(0, 2));
			write_reg(REG_DEBOUNCE, 16'(deb));
			if ($urandom_range(0, 2) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
			write_reg(REG_TARGET, tgt);

			now = phase == 4 ? 32'hFFFF_F000 : $urandom;
			for (k = 0; k < SWITCHES; k++)
				hold[2*k +: 2] = 2'($urandom_range(0, 2));
			// most phases start armed from the pins, the rest keep the old state
			if ($urandom_range(0, 3) != 0) begin
				pins = pins_of(hold);
				send_item(OP_ACTIVATE, now, pins[7:0], pins[15:8], 1'b0, RES_IDLE);
			end

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 12) begin
					k = $urandom_range(0, SWITCHES - 1);
					hold[2*k +: 2] = $urandom_range(0, 9) < 6 ? tgt[2*k +: 2]
						: 2'($urandom_range(0, 3));
				end
				pick = $urandom_range(0, 99);
				if (pick < 70)
					now += $urandom_range(0, deb / 3 + 1);
				else if (pick < 97)
					now += $urandom_range(deb / 2, deb + 2);
				else
					now += $urandom;
				pins = pins_of(hold);
				op = OP_TICK;
				pick = $urandom_range(0, 99);
				if (pick >= 93) begin
					op = 2'($urandom_range(0, 3));
					pins = 16'($urandom);
				end else if (pick >= 89) begin
					op = OP_ACTIVATE;
				end else if (pick == 88) begin
					op = OP_FORCE;
				end else if (pick == 87) begin
					op = OP_UNUSED;
				end else if (pick < 10) begin
					// contact bounce for one sample
					bounce = 16'($urandom) & 16'($urandom);
					pins ^= bounce;
				end
				send_item(op, now, pins[7:0], pins[15:8], 1'b0, RES_IDLE);
			end
		end

		wait_drained();
		repeat (4) @(posedge clk);
		$display("covered %0d items: %0d ticks, %0d activates, %0d force solves, %0d unused ops",
			op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3], op_seen[0], op_seen[1],
			op_seen[2], op_seen[3]);
		$display("%0d register writes, %0d results checked (%0d solved), %0d mismatches",
			writes_seen, results_seen, solved_seen, errors);
		if (errors == 0 && pending_status.size() == 0)
			$display("three_way_switch_debounce_match test passed");
		else
			$display("three_way_switch_debounce_match test failed");
		$finish;
	end

endmodule
